### design/integer_matrix_multiply_top_assert.svh
// Assertion macros used by the matrix multiply top level.
// Each macro expects clk and rst_n in scope.
`ifndef INTEGER_MATRIX_MULTIPLY_TOP_ASSERT_SVH
`define INTEGER_MATRIX_MULTIPLY_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define IMM_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define IMM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define IMM_ASSERT_IMP(lbl, ante, cons, msg)
`define IMM_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

### design/imm_pkg.sv
package imm_pkg;

    localparam int MAX_DIM = 8;
    localparam int DIM_W   = $clog2(MAX_DIM);
    localparam int ADDR_W  = 2 * DIM_W;
    localparam int DEPTH   = MAX_DIM * MAX_DIM;
    localparam int CFG_W   = 4;
    localparam int VAL_W   = 16;
    localparam int ACC_W   = 32;

    // Transaction modes
    localparam logic [1:0] MODE_LOAD_FIRST  = 2'd0;
    localparam logic [1:0] MODE_LOAD_SECOND = 2'd1;
    localparam logic [1:0] MODE_COMPUTE     = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] REG_ROWS_FIRST  = 2'd0;
    localparam logic [1:0] REG_INNER_DIM   = 2'd1;
    localparam logic [1:0] REG_COLS_SECOND = 2'd2;

    typedef struct packed {
        logic [1:0]              mode;
        logic [DIM_W-1:0]        elem_row;
        logic [DIM_W-1:0]        elem_col;
        logic signed [VAL_W-1:0] elem_value;
    } in_item_t;

    typedef struct packed {
        logic [DIM_W-1:0]        out_row;
        logic [DIM_W-1:0]        out_col;
        logic signed [ACC_W-1:0] product_value;
        logic                    last;
    } out_item_t;

    // Control that travels alongside each multiply-accumulate step
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } mac_ctl_t;

    // Highest index for a dimension register; zero acts as one, large values clamp.
    function automatic logic [DIM_W-1:0] dim_last(input logic [CFG_W-1:0] v);
        logic [DIM_W-1:0] r;
        if (v == '0)
            r = '0;
        else if (int'(v) > MAX_DIM)
            r = DIM_W'(MAX_DIM - 1);
        else
            r = DIM_W'(v - 1'b1);
        return r;
    endfunction

endpackage

### design/imm_store.sv
module imm_store (
    input  logic                                clk,
    input  logic                                we_first,
    input  logic                                we_second,
    input  logic [imm_pkg::ADDR_W-1:0]          wr_addr,
    input  logic signed [imm_pkg::VAL_W-1:0]    wr_data,
    input  logic [imm_pkg::ADDR_W-1:0]          rd_addr_a,
    input  logic [imm_pkg::ADDR_W-1:0]          rd_addr_b,
    output logic signed [imm_pkg::VAL_W-1:0]    rd_a,
    output logic signed [imm_pkg::VAL_W-1:0]    rd_b
);
    import imm_pkg::*;

    logic signed [VAL_W-1:0] first_mem  [0:DEPTH-1];
    logic signed [VAL_W-1:0] second_mem [0:DEPTH-1];
    logic signed [VAL_W-1:0] rd_a_reg;
    logic signed [VAL_W-1:0] rd_b_reg;

    always_ff @(posedge clk)
    begin
        if (we_first)
            first_mem[wr_addr] <= wr_data;
        rd_a_reg <= first_mem[rd_addr_a];
    end

    always_ff @(posedge clk)
    begin
        if (we_second)
            second_mem[wr_addr] <= wr_data;
        rd_b_reg <= second_mem[rd_addr_b];
    end

    assign rd_a = rd_a_reg;
    assign rd_b = rd_b_reg;

endmodule

### design/imm_mac.sv
module imm_mac (
    input  logic                                clk,
    input  logic                                rst_n,
    input  imm_pkg::mac_ctl_t                   ctl,
    input  logic signed [imm_pkg::VAL_W-1:0]    a,
    input  logic signed [imm_pkg::VAL_W-1:0]    b,
    output logic [imm_pkg::ACC_W-1:0]           acc,
    output logic                                done
);
    import imm_pkg::*;

    // ctl arrives with the read address; stage 1 lines up with the read data,
    // stage 2 with the product register.
    mac_ctl_t                ctl1_reg;
    mac_ctl_t                ctl2_reg;
    logic signed [ACC_W-1:0] prod_reg;
    logic [ACC_W-1:0]        acc_reg;
    logic [ACC_W-1:0]        acc_next;
    logic                    done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl1_reg <= '0;
            ctl2_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            ctl1_reg <= ctl;
            ctl2_reg <= ctl1_reg;
            done_reg <= ctl2_reg.valid && ctl2_reg.last;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= a * b;
        if (ctl2_reg.valid)
            acc_reg <= acc_next;
    end

    // Sum wraps modulo 2^32
    assign acc_next = ctl2_reg.first ? ACC_W'(prod_reg) : acc_reg + ACC_W'(prod_reg);

    assign acc  = acc_reg;
    assign done = done_reg;

endmodule

### design/integer_matrix_multiply_top.sv
// Integer matrix multiply.
// Input channel (in_valid / in_stall / in_data): each transaction either
// loads one 16-bit signed element of the first or second matrix at
// (elem_row, elem_col), or starts a compute; the unused mode is ignored.
// The block stays ready between loads, so loads stream back to back.
// A compute walks the stored matrices with one shared multiplier and
// accumulator, one multiply-accumulate per cycle while the inner index
// steps, and emits the product in row-major order on the output channel
// (out_valid / out_stall / out_data), with last set on the final element.
// Each product element goes through inner_dim read/MAC steps, then the
// read register, product register and accumulator, and then the output
// register; the next element starts only once that one is accepted.
// in_stall is high for the whole compute. While out_stall holds an
// element, the sequencer waits and the element stays unchanged.
// Configuration (cfg_we / cfg_index / cfg_data) is to be written by the
// user only while idle; the block itself does not enforce this.
// Reset sets all three dimensions to 8; matrix contents are undefined until
// loaded, and there is no clearing pass.
`include "integer_matrix_multiply_top_assert.svh"

module integer_matrix_multiply_top (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [1:0]                  cfg_index,
    input  logic [imm_pkg::CFG_W-1:0]   cfg_data,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  imm_pkg::in_item_t           in_data,
    output logic                        out_valid,
    input  logic                        out_stall,
    output imm_pkg::out_item_t          out_data
);
    import imm_pkg::*;

    typedef enum logic [1:0] {
        IDLE,
        RUN,
        DRAIN,
        EMIT
    } state_t;

    state_t           state_reg, state_next;
    logic [CFG_W-1:0] rows_first_reg;
    logic [CFG_W-1:0] inner_dim_reg;
    logic [CFG_W-1:0] cols_second_reg;
    logic [DIM_W-1:0] m_last_reg, m_last_next;
    logic [DIM_W-1:0] n_last_reg, n_last_next;
    logic [DIM_W-1:0] q_last_reg, q_last_next;
    logic [DIM_W-1:0] i_reg, i_next;
    logic [DIM_W-1:0] j_reg, j_next;
    logic [DIM_W-1:0] k_reg, k_next;
    logic             out_valid_reg, out_valid_next;
    out_item_t        out_data_reg, out_data_next;

    logic             idle_take;
    logic             elem_last;
    mac_ctl_t         mac_ctl;
    logic signed [VAL_W-1:0] rd_a;
    logic signed [VAL_W-1:0] rd_b;
    logic [ACC_W-1:0] mac_acc;
    logic             mac_done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_first_reg  <= CFG_W'(MAX_DIM);
            inner_dim_reg   <= CFG_W'(MAX_DIM);
            cols_second_reg <= CFG_W'(MAX_DIM);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ROWS_FIRST:  rows_first_reg  <= cfg_data;
                REG_INNER_DIM:   inner_dim_reg   <= cfg_data;
                REG_COLS_SECOND: cols_second_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign idle_take = in_valid && (state_reg == IDLE);
    assign elem_last = (i_reg == m_last_reg) && (j_reg == q_last_reg);

    assign mac_ctl.valid = (state_reg == RUN);
    assign mac_ctl.first = (k_reg == '0);
    assign mac_ctl.last  = (k_reg == n_last_reg);

    imm_store u_store (
        .clk       (clk),
        .we_first  (idle_take && (in_data.mode == MODE_LOAD_FIRST)),
        .we_second (idle_take && (in_data.mode == MODE_LOAD_SECOND)),
        .wr_addr   ({in_data.elem_row, in_data.elem_col}),
        .wr_data   (in_data.elem_value),
        .rd_addr_a ({i_reg, k_reg}),
        .rd_addr_b ({k_reg, j_reg}),
        .rd_a      (rd_a),
        .rd_b      (rd_b)
    );

    imm_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (mac_ctl),
        .a     (rd_a),
        .b     (rd_b),
        .acc   (mac_acc),
        .done  (mac_done)
    );

    always_comb
    begin
        state_next     = state_reg;
        m_last_next    = m_last_reg;
        n_last_next    = n_last_reg;
        q_last_next    = q_last_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        k_next         = k_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        unique case (state_reg)
            IDLE:
            begin
                if (in_valid && (in_data.mode == MODE_COMPUTE))
                begin
                    m_last_next = dim_last(rows_first_reg);
                    n_last_next = dim_last(inner_dim_reg);
                    q_last_next = dim_last(cols_second_reg);
                    i_next      = '0;
                    j_next      = '0;
                    k_next      = '0;
                    state_next  = RUN;
                end
            end
            RUN:
            begin
                if (k_reg == n_last_reg)
                    state_next = DRAIN;
                else
                    k_next = k_reg + 1'b1;
            end
            DRAIN:
            begin
                if (mac_done)
                begin
                    out_valid_next              = 1'b1;
                    out_data_next.out_row       = i_reg;
                    out_data_next.out_col       = j_reg;
                    out_data_next.product_value = signed'(mac_acc);
                    out_data_next.last          = elem_last;
                    state_next                  = EMIT;
                end
            end
            EMIT:
            begin
                if (!out_stall)
                begin
                    out_valid_next = 1'b0;
                    k_next         = '0;
                    if (j_reg == q_last_reg)
                    begin
                        j_next = '0;
                        i_next = i_reg + 1'b1;
                    end
                    else
                        j_next = j_reg + 1'b1;
                    state_next = elem_last ? IDLE : RUN;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= IDLE;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
            m_last_reg    <= '0;
            n_last_reg    <= '0;
            q_last_reg    <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
            m_last_reg    <= m_last_next;
            n_last_reg    <= n_last_next;
            q_last_reg    <= q_last_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            k_reg         <= k_next;
        end
    end

    assign in_stall  = (state_reg != IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    `IMM_ASSERT_IMP(a_out_only_in_emit, out_valid_reg, state_reg == EMIT, "result outside EMIT")
    `IMM_ASSERT_IMP(a_done_in_drain, mac_done, state_reg == DRAIN, "MAC finished outside DRAIN")
    `IMM_ASSERT_IMP(a_last_matches, out_valid_reg && out_data_reg.last,
        (out_data_reg.out_row == m_last_reg) && (out_data_reg.out_col == q_last_reg),
        "last flag on wrong element")
    `IMM_ASSERT_NEXT(a_k_steps, (state_reg == RUN) && (k_reg != n_last_reg),
        k_reg == DIM_W'($past(k_reg) + 1'b1), "inner index skipped")

endmodule

### bench/integer_matrix_multiply_top_tb.sv
module integer_matrix_multiply_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import imm_pkg::*;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam logic [1:0] REG_UNUSED  = 2'd3;

    localparam int RANDOM_ITEMS   = 370;
    localparam int SETTLE_CYCLES  = 16;
    localparam int WATCHDOG_LIMIT = 4000;

    typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_style_t;

    // One step of the directed sequence: either a register update or a transaction.
    typedef struct {
        bit               is_dims;
        logic [CFG_W-1:0] rows;
        logic [CFG_W-1:0] inner;
        logic [CFG_W-1:0] cols;
        in_item_t         item;
        bit               typed;
        out_item_t        want;
    } plan_row_t;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             cfg_we    = 1'b0;
    logic [1:0]       cfg_index = REG_ROWS_FIRST;
    logic [CFG_W-1:0] cfg_data  = '0;
    logic             in_valid  = 1'b0;
    logic             in_stall;
    in_item_t         in_data   = '0;
    logic             out_valid;
    logic             out_stall = 1'b0;
    out_item_t        out_data;

    // Shadow copy of both matrices and the dimension registers.
    logic signed [VAL_W-1:0] first_mat  [DEPTH];
    logic signed [VAL_W-1:0] second_mat [DEPTH];
    bit                      first_set  [DEPTH];
    bit                      second_set [DEPTH];
    logic [CFG_W-1:0]        dim_rows  = 4'd8;
    logic [CFG_W-1:0]        dim_inner = 4'd8;
    logic [CFG_W-1:0]        dim_cols  = 4'd8;

    out_item_t    pending_products [$];
    int           items_sent  = 0;
    int           errors      = 0;
    int           burst_left  = 0;
    int           idle_cycles = 0;
    int           stall_left  = 0;
    stall_style_t stall_style = STALL_NONE;
    bit           in_fire     = 1'b0;
    bit           out_fire    = 1'b0;

    integer_matrix_multiply_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    function automatic int eff_dim(logic [CFG_W-1:0] v);
        if (v == '0)
            return 1;
        if (int'(v) > MAX_DIM)
            return MAX_DIM;
        return int'(v);
    endfunction

    function automatic bit operands_ready();
        int m;
        int n;
        int q;
        m = eff_dim(dim_rows);
        n = eff_dim(dim_inner);
        q = eff_dim(dim_cols);
        for (int i = 0; i < m; i++)
            for (int k = 0; k < n; k++)
                if (!first_set[i * MAX_DIM + k])
                    return 1'b0;
        for (int k = 0; k < n; k++)
            for (int j = 0; j < q; j++)
                if (!second_set[k * MAX_DIM + j])
                    return 1'b0;
        return 1'b1;
    endfunction

    // Stores a loaded element, or queues the whole product matrix for a compute.
    function automatic void load_or_multiply(in_item_t it);
        int                      m;
        int                      n;
        int                      q;
        logic [ACC_W-1:0]        acc;
        logic signed [ACC_W-1:0] term;
        out_item_t               prod;
        case (it.mode)
            MODE_LOAD_FIRST:
            begin
                first_mat[{it.elem_row, it.elem_col}] = it.elem_value;
                first_set[{it.elem_row, it.elem_col}] = 1'b1;
            end
            MODE_LOAD_SECOND:
            begin
                second_mat[{it.elem_row, it.elem_col}] = it.elem_value;
                second_set[{it.elem_row, it.elem_col}] = 1'b1;
            end
            MODE_COMPUTE:
            begin
                m = eff_dim(dim_rows);
                n = eff_dim(dim_inner);
                q = eff_dim(dim_cols);
                for (int i = 0; i < m; i++)
                begin
                    for (int j = 0; j < q; j++)
                    begin
                        acc = '0;
                        for (int k = 0; k < n; k++)
                        begin
                            term = first_mat[i * MAX_DIM + k] * second_mat[k * MAX_DIM + j];
                            acc += term;
                        end
                        prod.out_row       = DIM_W'(i);
                        prod.out_col       = DIM_W'(j);
                        prod.product_value = acc;
                        prod.last          = (i == m - 1) && (j == q - 1);
                        pending_products.push_back(prod);
                    end
                end
            end
            default: ;
        endcase
    endfunction

    function automatic logic [VAL_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'hFFFF;
            3: return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] pick_dim();
        case ($urandom_range(0, 15))
            0: return 4'd0;
            1: return 4'd15;
            2: return 4'd8;
            3: return 4'($urandom_range(9, 14));
            default: return 4'($urandom_range(1, 4));
        endcase
    endfunction

    function automatic in_item_t random_item(logic [1:0] mode);
        in_item_t it;
        it.mode       = mode;
        it.elem_row   = DIM_W'($urandom);
        it.elem_col   = DIM_W'($urandom);
        it.elem_value = pick_value();
        return it;
    endfunction

    function automatic plan_row_t item_row(logic [1:0] mode, int r, int c, logic [VAL_W-1:0] v);
        plan_row_t row;
        row.is_dims         = 1'b0;
        row.rows            = '0;
        row.inner           = '0;
        row.cols            = '0;
        row.item.mode       = mode;
        row.item.elem_row   = DIM_W'(r);
        row.item.elem_col   = DIM_W'(c);
        row.item.elem_value = v;
        row.typed           = 1'b0;
        row.want            = '0;
        return row;
    endfunction

    // Single-element product: always lands at (0,0) with last set.
    function automatic plan_row_t checked_row(int r, int c, logic [VAL_W-1:0] v,
                                              logic [ACC_W-1:0] result);
        plan_row_t row;
        row                    = item_row(MODE_COMPUTE, r, c, v);
        row.typed              = 1'b1;
        row.want.out_row       = '0;
        row.want.out_col       = '0;
        row.want.product_value = result;
        row.want.last          = 1'b1;
        return row;
    endfunction

    function automatic plan_row_t dims_row(logic [CFG_W-1:0] r, logic [CFG_W-1:0] i,
                                           logic [CFG_W-1:0] c);
        plan_row_t row;
        row         = item_row(MODE_UNUSED, 0, 0, '0);
        row.is_dims = 1'b1;
        row.rows    = r;
        row.inner   = i;
        row.cols    = c;
        return row;
    endfunction

    task automatic send_item(input in_item_t it, input bit typed, input out_item_t want);
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 8);
            if ($urandom_range(0, 2) != 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
        in_valid <= 1'b1;
        in_data  <= it;
        // inputs settle by the falling edge; the transaction completes on the next rising edge
        @(negedge clk);
        while (in_stall !== 1'b0)
        begin
            @(posedge clk);
            @(negedge clk);
        end
        if (typed)
            pending_products.push_back(want);
        else
            load_or_multiply(it);
        if (it.mode != MODE_UNUSED)
            items_sent++;
        burst_left--;
        @(posedge clk);
    endtask

    task automatic drain_products();
        in_valid <= 1'b0;
        while (pending_products.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_regs(input logic [CFG_W-1:0] rows, input logic [CFG_W-1:0] inner,
                              input logic [CFG_W-1:0] cols, input logic [CFG_W-1:0] junk,
                              input logic [3:0] mask);
        logic [1:0]       codes [4];
        logic [CFG_W-1:0] vals  [4];
        codes[0] = REG_ROWS_FIRST;
        codes[1] = REG_INNER_DIM;
        codes[2] = REG_COLS_SECOND;
        codes[3] = REG_UNUSED;
        vals[0]  = rows;
        vals[1]  = inner;
        vals[2]  = cols;
        vals[3]  = junk;
        for (int r = 0; r < 4; r++)
        begin
            if (mask[r])
            begin
                cfg_we    <= 1'b1;
                cfg_index <= codes[r];
                cfg_data  <= vals[r];
                @(posedge clk);
                case (codes[r])
                    REG_ROWS_FIRST:  dim_rows  = vals[r];
                    REG_INNER_DIM:   dim_inner = vals[r];
                    REG_COLS_SECOND: dim_cols  = vals[r];
                    default: ;
                endcase
            end
        end
        cfg_we <= 1'b0;
    endtask

    // Output check: sampled at the falling edge, ahead of the accepting rising edge.
    always @(negedge clk)
    begin
        out_item_t want;
        in_fire  = rst_n && (in_valid === 1'b1) && (in_stall === 1'b0);
        out_fire = rst_n && (out_valid === 1'b1) && (out_stall === 1'b0);
        if (out_fire)
        begin
            if (pending_products.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected product, expected none, got row %0d col %0d value %0d last %0b",
                         $time, out_data.out_row, out_data.out_col, out_data.product_value,
                         out_data.last);
            end
            else
            begin
                want = pending_products.pop_front();
                if (out_data.out_row !== want.out_row)
                begin
                    errors++;
                    $display("%0t: out_row expected %0d got %0d", $time, want.out_row,
                             out_data.out_row);
                end
                if (out_data.out_col !== want.out_col)
                begin
                    errors++;
                    $display("%0t: out_col expected %0d got %0d", $time, want.out_col,
                             out_data.out_col);
                end
                if (out_data.product_value !== want.product_value)
                begin
                    errors++;
                    $display("%0t: product_value expected %0d got %0d", $time,
                             want.product_value, out_data.product_value);
                end
                if (out_data.last !== want.last)
                begin
                    errors++;
                    $display("%0t: last expected %0b got %0b", $time, want.last, out_data.last);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_style <= stall_style_t'($urandom_range(0, 3));
            stall_left  <= $urandom_range(16, 160);
        end
        else
        begin
            stall_left <= stall_left - 1;
        end
        case (stall_style)
            STALL_NONE:   out_stall <= 1'b0;
            STALL_LIGHT:  out_stall <= ($urandom_range(0, 99) < 25);
            STALL_HEAVY:  out_stall <= ($urandom_range(0, 99) < 75);
            STALL_TOGGLE: out_stall <= ~out_stall;
            default:      out_stall <= 1'b0;
        endcase
    end

    always @(posedge clk)
    begin
        if (!rst_n || in_fire || out_fire)
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles == WATCHDOG_LIMIT)
        begin
            $display("integer_matrix_multiply_top_tb NOT OK");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        plan_row_t        plan  [$];
        in_item_t         loads [$];
        in_item_t         it;
        in_item_t         tmp;
        int               start;
        int               phase;
        int               m;
        int               n;
        int               q;
        int               t;
        logic [CFG_W-1:0] rows;
        logic [CFG_W-1:0] inner;
        logic [CFG_W-1:0] cols;
        logic [3:0]       mask;

        plan = '{
            dims_row(4'd1, 4'd1, 4'd1),
            item_row(MODE_LOAD_FIRST, 0, 0, 16'h8000),
            item_row(MODE_LOAD_SECOND, 0, 0, 16'h8000),
            checked_row(0, 0, 16'h0000, 32'h4000_0000),
            item_row(MODE_LOAD_SECOND, 0, 0, 16'h7FFF),
            checked_row(0, 0, 16'h0000, 32'hC000_8000),
            item_row(MODE_LOAD_FIRST, 0, 0, 16'h7FFF),
            checked_row(0, 0, 16'h0000, 32'h3FFF_0001),
            // unused mode, then a compute with every ignored bit set
            item_row(MODE_UNUSED, 7, 7, 16'hFFFF),
            checked_row(7, 7, 16'hFFFF, 32'h3FFF_0001),
            // zero dimensions act as one
            dims_row(4'd0, 4'd0, 4'd0),
            checked_row(5, 2, 16'h1234, 32'h3FFF_0001),
            // two products of full-scale negative operands wrap past the top of the range
            dims_row(4'd1, 4'd2, 4'd1),
            item_row(MODE_LOAD_FIRST, 0, 0, 16'h8000),
            item_row(MODE_LOAD_FIRST, 0, 1, 16'h8000),
            item_row(MODE_LOAD_SECOND, 0, 0, 16'h8000),
            item_row(MODE_LOAD_SECOND, 1, 0, 16'h8000),
            checked_row(0, 0, 16'h0000, 32'h8000_0000),
            // 2x2 product; the corner load sits outside the configured size
            dims_row(4'd2, 4'd2, 4'd2),
            item_row(MODE_LOAD_FIRST, 1, 0, 16'h0001),
            item_row(MODE_LOAD_FIRST, 1, 1, 16'hFFFF),
            item_row(MODE_LOAD_SECOND, 0, 1, 16'h7FFF),
            item_row(MODE_LOAD_SECOND, 1, 1, 16'h8000),
            item_row(MODE_LOAD_SECOND, 7, 7, 16'h5A5A),
            item_row(MODE_COMPUTE, 0, 0, 16'h0000)
        };

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[p])
        begin
            if (plan[p].is_dims)
            begin
                drain_products();
                write_regs(plan[p].rows, plan[p].inner, plan[p].cols, 4'hF, 4'b1111);
            end
            else
            begin
                send_item(plan[p].item, plan[p].typed, plan[p].want);
            end
        end

        // Random phases: reprogram while idle, fill the operand region, then compute.
        start = items_sent;
        phase = 0;
        while (items_sent - start < RANDOM_ITEMS)
        begin
            case (phase)
                0:
                begin
                    rows  = 4'd15;
                    inner = 4'd15;
                    cols  = 4'd15;
                    mask  = 4'b0111;
                end
                1:
                begin
                    rows  = 4'd8;
                    inner = 4'd0;
                    cols  = 4'd15;
                    mask  = 4'b0111;
                end
                default:
                begin
                    rows  = pick_dim();
                    inner = pick_dim();
                    cols  = pick_dim();
                    mask  = 4'($urandom_range(1, 7));
                end
            endcase
            if ($urandom_range(0, 3) == 0)
                mask[3] = 1'b1;
            drain_products();
            write_regs(rows, inner, cols, 4'($urandom), mask);

            m = eff_dim(dim_rows);
            n = eff_dim(dim_inner);
            q = eff_dim(dim_cols);
            loads.delete();
            for (int i = 0; i < m; i++)
                for (int k = 0; k < n; k++)
                    if (!first_set[i * MAX_DIM + k] || $urandom_range(0, 3) != 0)
                    begin
                        it          = random_item(MODE_LOAD_FIRST);
                        it.elem_row = DIM_W'(i);
                        it.elem_col = DIM_W'(k);
                        loads.push_back(it);
                    end
            for (int k = 0; k < n; k++)
                for (int j = 0; j < q; j++)
                    if (!second_set[k * MAX_DIM + j] || $urandom_range(0, 3) != 0)
                    begin
                        it          = random_item(MODE_LOAD_SECOND);
                        it.elem_row = DIM_W'(k);
                        it.elem_col = DIM_W'(j);
                        loads.push_back(it);
                    end
            for (int s = loads.size() - 1; s > 0; s--)
            begin
                t        = $urandom_range(0, s);
                tmp      = loads[s];
                loads[s] = loads[t];
                loads[t] = tmp;
            end

            foreach (loads[l])
            begin
                case ($urandom_range(0, 19))
                    0, 1: send_item(random_item(MODE_UNUSED), 1'b0, '0);
                    2, 3: send_item(random_item($urandom_range(0, 1) ? MODE_LOAD_SECOND
                                                                     : MODE_LOAD_FIRST),
                                    1'b0, '0);
                    4:
                    begin
                        // early compute on whatever is stored, only once every operand exists
                        if (operands_ready())
                            send_item(random_item(MODE_COMPUTE), 1'b0, '0);
                    end
                    default: ;
                endcase
                send_item(loads[l], 1'b0, '0);
            end

            if ($urandom_range(0, 3) == 0)
                drain_products();
            send_item(random_item(MODE_COMPUTE), 1'b0, '0);
            if ($urandom_range(0, 2) == 0)
                send_item(random_item(MODE_COMPUTE), 1'b0, '0);
            phase++;
        end

        drain_products();
        if (errors == 0)
            $display("integer_matrix_multiply_top_tb OK");
        else
            $display("integer_matrix_multiply_top_tb NOT OK");
        $finish;
    end

endmodule

### integer_matrix_multiply_top.f
+incdir+design
design/imm_pkg.sv
design/imm_store.sv
design/imm_mac.sv
design/integer_matrix_multiply_top.sv
bench/integer_matrix_multiply_top_tb.sv
